// ===== rtl/core/aufifo_pkg.sv =====
// shared types and constants for the audio fifo with underrun fade
// item and result word layouts, register indexes, source codes
// no dependencies
package aufifo_pkg;

    localparam int CHAN_W     = 4;
    localparam int FRAMES_W   = 11;
    localparam int SAMPLE_W   = 16;
    localparam int CSAMP_W    = 13;
    localparam int FILL_W     = 15;
    localparam int POS_W      = CHAN_W + FRAMES_W;
    localparam int WANT_W     = POS_W + 1;
    localparam int PROD_W     = SAMPLE_W + FRAMES_W;
    localparam int DIV_STEPS  = SAMPLE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = FRAMES_W;

    localparam int DEF_RING_DEPTH  = 4096;
    localparam int DEF_CHUNK_DEPTH = 2048;

    localparam logic [CHAN_W-1:0]   RST_CHANNEL_COUNT = CHAN_W'(2);
    localparam logic [FRAMES_W-1:0] RST_CHUNK_FRAMES  = FRAMES_W'(512);

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_FRAMES  = CFG_IDX_W'(1);

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_PULL = 1'b1;

    typedef enum logic [1:0] {
        SRC_RING    = 2'd0,
        SRC_FADE    = 2'd1,
        SRC_SILENCE = 2'd2,
        SRC_PUSH    = 2'd3
    } src_t;

    typedef struct packed {
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample;
        logic [CSAMP_W-1:0]         chunk_samples;
        logic [FRAMES_W-1:0]        burst_frames;
        logic                       first;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       accepted;
        logic [FILL_W-1:0]          fill_frames;
        src_t                       source;
    } result_t;

endpackage

// ===== rtl/core/aufifo_ram.sv =====
// generic single write port, single read port ram with registered read data
// no package dependencies
module aufifo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/audio_fifo_underrun_fade.sv =====
// pcm sample fifo with underrun concealment by a faded replay of the last burst
// depends on aufifo_pkg and aufifo_ram
//
// item channel (item_valid / item_stall / item): one word per pushed or pulled
//   sample. a push chunk is taken whole or dropped, decided on its first word.
//   a pull burst picks ring, faded replay or silence on its first word.
// result channel (result_valid / result_stall / result): one word per item.
// config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): channel_count
//   at index 0, chunk_frames at index 1; a write empties the ring and the
//   replay store and restarts burst state.
// from accept to result, push and silence pass the decide, act and done states;
//   a ring read adds a read-data state and a faded sample adds multiply, divide
//   and fix states. the next item is taken in idle once the result is loaded.
//   fade division uses the 16 step restoring divider, one quotient bit per cycle.
// after reset and after each config write the block computes ring capacity and
//   replay size in its setup state before it takes an item. the replay store is
//   cleared through a high-water mark, so there is no clearing pass.
// a stalled result waits in the output register while the next item is taken.
module audio_fifo_underrun_fade
    import aufifo_pkg::*;
#(
    parameter int RING_DEPTH  = DEF_RING_DEPTH,
    parameter int CHUNK_DEPTH = DEF_CHUNK_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result
);

    localparam int RING_AW  = $clog2(RING_DEPTH);
    localparam int PTR_W    = RING_AW + 1;
    localparam int PW1      = PTR_W + 1;
    localparam int CHUNK_AW = $clog2(CHUNK_DEPTH);
    localparam int RS_W     = $clog2(CHUNK_DEPTH + 1);
    localparam int CMP_W    = (PTR_W > WANT_W) ? PTR_W : WANT_W;

    typedef enum logic [8:0] {
        S_SETUP  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_ACT    = 9'b000001000,
        S_RDATA  = 9'b000010000,
        S_MUL    = 9'b000100000,
        S_DIV    = 9'b001000000,
        S_FIX    = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    // control registers
    state_t              state_reg, state_next;
    logic [CHAN_W-1:0]   chan_cfg_reg, chan_cfg_next;
    logic [FRAMES_W-1:0] frames_cfg_reg, frames_cfg_next;
    logic [CHAN_W-1:0]   ch_reg, ch_next;
    logic [PTR_W-1:0]    cap_reg, cap_next;
    logic [RS_W-1:0]     rsize_reg, rsize_next;
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [RS_W-1:0]     hw_reg, hw_next;
    logic                replay_valid_reg, replay_valid_next;
    logic                faded_reg, faded_next;
    logic                accepting_reg, accepting_next;
    src_t                mode_reg, mode_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [FRAMES_W-1:0] burst_length_reg, burst_length_next;
    logic [POS_W-1:0]    burst_n_reg, burst_n_next;
    logic                saving_reg, saving_next;
    logic [FRAMES_W-1:0] fi_reg, fi_next;
    logic [CHAN_W-1:0]   bsub_reg, bsub_next;
    logic [PTR_W-1:0]    fill_reg, fill_next;
    logic [CHAN_W-1:0]   fsub_reg, fsub_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                out_valid_reg, out_valid_next;

    // payload registers
    item_t               in_reg, in_next;
    logic [FRAMES_W-1:0] rem_reg, rem_next;
    logic [SAMPLE_W-1:0] quo_reg, quo_next;
    logic                neg_reg, neg_next;
    result_t             res_reg, res_next;
    result_t             out_reg, out_next;

    // derived values
    logic [CHAN_W-1:0]   ch_eff;
    logic [CHAN_W-1:0]   ch_m1;
    logic [POS_W-1:0]    chunk_size;
    logic [WANT_W-1:0]   want;
    logic [PTR_W-1:0]    cap_calc;
    logic                cap_found;
    logic [RS_W-1:0]     rsize_calc;
    logic [PW1-1:0]      two_cap;
    logic [PW1-1:0]      avail_wide;
    logic [PTR_W-1:0]    avail;
    logic [PW1-1:0]      wr_inc;
    logic [PW1-1:0]      rd_inc;
    logic [PTR_W-1:0]    wr_ptr_adv;
    logic [PTR_W-1:0]    rd_ptr_adv;
    logic [RING_AW-1:0]  slot_w;
    logic [RING_AW-1:0]  slot_r;
    logic [POS_W-1:0]    burst_n_calc;
    logic [POS_W-1:0]    pos_adv;
    logic [FRAMES_W-1:0] fi_adv;
    logic [CHAN_W-1:0]   bsub_adv;
    logic signed [SAMPLE_W-1:0] fade_s;
    logic [SAMPLE_W-1:0] fade_mag;
    logic [FRAMES_W-1:0] fade_gain;
    logic [PROD_W-1:0]   fade_prod;
    logic [FRAMES_W:0]   div_trial;
    logic                div_ge;

    // memory ports
    logic                ring_we;
    logic [RING_AW-1:0]  ring_wr_addr;
    logic [RING_AW-1:0]  ring_rd_addr;
    logic [SAMPLE_W-1:0] ring_rdata;
    logic                replay_we;
    logic [CHUNK_AW-1:0] replay_wr_addr;
    logic [CHUNK_AW-1:0] replay_rd_addr;
    logic [SAMPLE_W-1:0] replay_rdata;

    aufifo_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (ring_wr_addr),
        .wr_data (in_reg.sample),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rdata)
    );

    aufifo_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (CHUNK_DEPTH)
    ) u_replay (
        .clk     (clk),
        .wr_en   (replay_we),
        .wr_addr (replay_wr_addr),
        .wr_data (ring_rdata),
        .rd_addr (replay_rd_addr),
        .rd_data (replay_rdata)
    );

    assign cfg_ready    = (state_reg != S_SETUP);
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // ring capacity and replay size from the config registers
    assign ch_eff     = (chan_cfg_reg == '0) ? CHAN_W'(1) : chan_cfg_reg;
    assign chunk_size = POS_W'(frames_cfg_reg) * POS_W'(ch_eff);
    assign want       = {chunk_size, 1'b0};

    always_comb
    begin
        cap_calc  = PTR_W'(RING_DEPTH);
        cap_found = 1'b0;
        for (int k = 0; k <= RING_AW; k++)
        begin
            if (!cap_found && ((CMP_W'(1) << k) >= CMP_W'(want)))
            begin
                cap_found = 1'b1;
                if ((CMP_W'(1) << k) < CMP_W'(RING_DEPTH))
                begin
                    cap_calc = PTR_W'(CMP_W'(1) << k);
                end
            end
        end
        if (want == '0)
        begin
            cap_calc = '0;
        end
    end

    assign rsize_calc = (CMP_W'(chunk_size) > CMP_W'(CHUNK_DEPTH)) ?
                        RS_W'(CHUNK_DEPTH) : RS_W'(chunk_size);

    // ring occupancy, pointers count modulo twice the capacity
    assign two_cap = {cap_reg, 1'b0};

    always_comb
    begin
        if (wr_ptr_reg >= rd_ptr_reg)
        begin
            avail_wide = PW1'(wr_ptr_reg) - PW1'(rd_ptr_reg);
        end
        else
        begin
            avail_wide = PW1'(wr_ptr_reg) + two_cap - PW1'(rd_ptr_reg);
        end
    end

    assign avail      = PTR_W'(avail_wide);
    assign wr_inc     = PW1'(wr_ptr_reg) + PW1'(1);
    assign rd_inc     = PW1'(rd_ptr_reg) + PW1'(1);
    assign wr_ptr_adv = (wr_inc >= two_cap) ? '0 : PTR_W'(wr_inc);
    assign rd_ptr_adv = (rd_inc >= two_cap) ? '0 : PTR_W'(rd_inc);
    assign slot_w     = (wr_ptr_reg >= cap_reg) ? RING_AW'(wr_ptr_reg - cap_reg)
                                                : RING_AW'(wr_ptr_reg);
    assign slot_r     = (rd_ptr_reg >= cap_reg) ? RING_AW'(rd_ptr_reg - cap_reg)
                                                : RING_AW'(rd_ptr_reg);

    assign ch_m1        = ch_reg - CHAN_W'(1);
    assign burst_n_calc = POS_W'(in_reg.burst_frames) * POS_W'(ch_reg);

    // burst position with its frame index kept alongside
    assign pos_adv  = pos_reg + POS_W'(1);
    assign fi_adv   = (bsub_reg == ch_m1) ? fi_reg + FRAMES_W'(1) : fi_reg;
    assign bsub_adv = (bsub_reg == ch_m1) ? '0 : bsub_reg + CHAN_W'(1);

    // fade gain: |s| * (n - i), then divided by n in the divider
    assign fade_s    = (CMP_W'(pos_reg) < CMP_W'(hw_reg)) ? $signed(replay_rdata) : '0;
    assign fade_mag  = fade_s[SAMPLE_W-1] ? SAMPLE_W'(-fade_s) : $unsigned(fade_s);
    assign fade_gain = burst_length_reg - fi_reg;
    assign fade_prod = PROD_W'(fade_mag) * PROD_W'(fade_gain);

    assign div_trial = {rem_reg, quo_reg[SAMPLE_W-1]};
    assign div_ge    = (div_trial >= {1'b0, burst_length_reg});

    always_comb
    begin
        state_next        = state_reg;
        chan_cfg_next     = chan_cfg_reg;
        frames_cfg_next   = frames_cfg_reg;
        ch_next           = ch_reg;
        cap_next          = cap_reg;
        rsize_next        = rsize_reg;
        wr_ptr_next       = wr_ptr_reg;
        rd_ptr_next       = rd_ptr_reg;
        hw_next           = hw_reg;
        replay_valid_next = replay_valid_reg;
        faded_next        = faded_reg;
        accepting_next    = accepting_reg;
        mode_next         = mode_reg;
        pos_next          = pos_reg;
        burst_length_next = burst_length_reg;
        burst_n_next      = burst_n_reg;
        saving_next       = saving_reg;
        fi_next           = fi_reg;
        bsub_next         = bsub_reg;
        fill_next         = fill_reg;
        fsub_next         = fsub_reg;
        div_cnt_next      = div_cnt_reg;
        out_valid_next    = out_valid_reg;
        in_next           = in_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        neg_next          = neg_reg;
        res_next          = res_reg;
        out_next          = out_reg;
        ring_we           = 1'b0;
        ring_wr_addr      = slot_w;
        ring_rd_addr      = slot_r;
        replay_we         = 1'b0;
        replay_wr_addr    = CHUNK_AW'(pos_reg);
        replay_rd_addr    = CHUNK_AW'(pos_reg);

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_SETUP:
            begin
                ch_next    = ch_eff;
                cap_next   = cap_calc;
                rsize_next = rsize_calc;
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (item_valid)
                begin
                    in_next    = item;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (in_reg.first)
                begin
                    if (in_reg.action == ACT_PUSH)
                    begin
                        // whole chunk must fit in the free space
                        accepting_next = (CMP_W'(cap_reg - avail) >=
                                          CMP_W'(in_reg.chunk_samples));
                    end
                    else
                    begin
                        burst_length_next = in_reg.burst_frames;
                        burst_n_next      = burst_n_calc;
                        pos_next          = '0;
                        fi_next           = '0;
                        bsub_next         = '0;
                        saving_next       = 1'b0;
                        if (in_reg.burst_frames == '0)
                        begin
                            mode_next = SRC_SILENCE;
                        end
                        else if (CMP_W'(avail) >= CMP_W'(burst_n_calc))
                        begin
                            mode_next  = SRC_RING;
                            faded_next = 1'b0;
                            if (CMP_W'(burst_n_calc) <= CMP_W'(rsize_reg))
                            begin
                                saving_next       = 1'b1;
                                replay_valid_next = 1'b1;
                            end
                        end
                        else if (replay_valid_reg && !faded_reg)
                        begin
                            mode_next  = SRC_FADE;
                            faded_next = 1'b1;
                        end
                        else
                        begin
                            mode_next = SRC_SILENCE;
                        end
                    end
                end
                state_next = S_ACT;
            end

            S_ACT:
            begin
                res_next.sample_out  = '0;
                res_next.accepted    = 1'b0;
                res_next.fill_frames = '0;
                res_next.source      = SRC_SILENCE;
                state_next           = S_DONE;
                if (in_reg.action == ACT_PUSH)
                begin
                    res_next.source = SRC_PUSH;
                    if (accepting_reg && (avail < cap_reg))
                    begin
                        ring_we           = 1'b1;
                        wr_ptr_next       = wr_ptr_adv;
                        res_next.accepted = 1'b1;
                        if (fsub_reg == ch_m1)
                        begin
                            fsub_next = '0;
                            fill_next = fill_reg + PTR_W'(1);
                        end
                        else
                        begin
                            fsub_next = fsub_reg + CHAN_W'(1);
                        end
                    end
                end
                else if ((pos_reg < burst_n_reg) && (mode_reg != SRC_SILENCE))
                begin
                    case (mode_reg)
                        SRC_RING:
                        begin
                            if (avail != '0)
                            begin
                                state_next = S_RDATA;
                            end
                            else
                            begin
                                // ring ran dry mid burst
                                pos_next  = pos_adv;
                                fi_next   = fi_adv;
                                bsub_next = bsub_adv;
                            end
                        end
                        SRC_FADE:
                        begin
                            state_next = S_MUL;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_RDATA:
            begin
                rd_ptr_next         = rd_ptr_adv;
                res_next.sample_out = $signed(ring_rdata);
                res_next.source     = SRC_RING;
                if (fsub_reg == '0)
                begin
                    fsub_next = ch_m1;
                    fill_next = fill_reg - PTR_W'(1);
                end
                else
                begin
                    fsub_next = fsub_reg - CHAN_W'(1);
                end
                if (saving_reg && (CMP_W'(pos_reg) < CMP_W'(rsize_reg)))
                begin
                    replay_we = 1'b1;
                    if (CMP_W'(pos_reg) >= CMP_W'(hw_reg))
                    begin
                        hw_next = RS_W'(pos_adv);
                    end
                end
                pos_next   = pos_adv;
                fi_next    = fi_adv;
                bsub_next  = bsub_adv;
                state_next = S_DONE;
            end

            S_MUL:
            begin
                neg_next     = fade_s[SAMPLE_W-1];
                rem_next     = fade_prod[PROD_W-1:SAMPLE_W];
                quo_next     = fade_prod[SAMPLE_W-1:0];
                div_cnt_next = DIV_CNT_W'(DIV_STEPS - 1);
                state_next   = S_DIV;
            end

            S_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (div_ge)
                begin
                    rem_next = FRAMES_W'(div_trial - {1'b0, burst_length_reg});
                end
                else
                begin
                    rem_next = div_trial[FRAMES_W-1:0];
                end
                quo_next = {quo_reg[SAMPLE_W-2:0], div_ge};
                if (div_cnt_reg == '0)
                begin
                    state_next = S_FIX;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                end
            end

            S_FIX:
            begin
                res_next.sample_out = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
                res_next.source     = SRC_FADE;
                pos_next            = pos_adv;
                fi_next             = fi_adv;
                bsub_next           = bsub_adv;
                state_next          = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next             = res_reg;
                    out_next.fill_frames = FILL_W'(fill_reg);
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_SETUP;
            end
        endcase

        // a register write reopens the fifo
        if (cfg_valid && cfg_ready &&
            ((cfg_index == CFG_CHANNEL_COUNT) || (cfg_index == CFG_CHUNK_FRAMES)))
        begin
            if (cfg_index == CFG_CHANNEL_COUNT)
            begin
                chan_cfg_next = cfg_data[CHAN_W-1:0];
            end
            else
            begin
                frames_cfg_next = cfg_data;
            end
            wr_ptr_next       = '0;
            rd_ptr_next       = '0;
            hw_next           = '0;
            replay_valid_next = 1'b0;
            faded_next        = 1'b0;
            accepting_next    = 1'b0;
            mode_next         = SRC_SILENCE;
            pos_next          = '0;
            burst_length_next = '0;
            burst_n_next      = '0;
            saving_next       = 1'b0;
            fi_next           = '0;
            bsub_next         = '0;
            fill_next         = '0;
            fsub_next         = '0;
            state_next        = S_SETUP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_SETUP;
            chan_cfg_reg     <= RST_CHANNEL_COUNT;
            frames_cfg_reg   <= RST_CHUNK_FRAMES;
            ch_reg           <= CHAN_W'(1);
            cap_reg          <= '0;
            rsize_reg        <= '0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            hw_reg           <= '0;
            replay_valid_reg <= 1'b0;
            faded_reg        <= 1'b0;
            accepting_reg    <= 1'b0;
            mode_reg         <= SRC_SILENCE;
            pos_reg          <= '0;
            burst_length_reg <= '0;
            burst_n_reg      <= '0;
            saving_reg       <= 1'b0;
            fi_reg           <= '0;
            bsub_reg         <= '0;
            fill_reg         <= '0;
            fsub_reg         <= '0;
            div_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            chan_cfg_reg     <= chan_cfg_next;
            frames_cfg_reg   <= frames_cfg_next;
            ch_reg           <= ch_next;
            cap_reg          <= cap_next;
            rsize_reg        <= rsize_next;
            wr_ptr_reg       <= wr_ptr_next;
            rd_ptr_reg       <= rd_ptr_next;
            hw_reg           <= hw_next;
            replay_valid_reg <= replay_valid_next;
            faded_reg        <= faded_next;
            accepting_reg    <= accepting_next;
            mode_reg         <= mode_next;
            pos_reg          <= pos_next;
            burst_length_reg <= burst_length_next;
            burst_n_reg      <= burst_n_next;
            saving_reg       <= saving_next;
            fi_reg           <= fi_next;
            bsub_reg         <= bsub_next;
            fill_reg         <= fill_next;
            fsub_reg         <= fsub_next;
            div_cnt_reg      <= div_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg  <= in_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

`ifndef NO_ASSERTIONS
    a_ring_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
        avail <= cap_reg)
        else $error("ring occupancy above capacity");

    a_fill_split: assert property (@(posedge clk) disable iff (!rst_n)
        (fsub_reg < ch_reg) &&
        ((fill_reg * PTR_W'(ch_reg)) + PTR_W'(fsub_reg) == avail))
        else $error("frame count out of step with ring pointers");

    a_replay_mark: assert property (@(posedge clk) disable iff (!rst_n)
        hw_reg <= rsize_reg)
        else $error("replay high-water mark beyond replay size");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < burst_length_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule

// ===== verif/audio_fifo_underrun_fade_tb.sv =====
`timescale 1ns / 100ps
// testbench for audio_fifo_underrun_fade: directed and random push/pull traffic,
// every result word checked against a behavioral model of the ring, replay and fade
// depends on aufifo_pkg and the audio_fifo_underrun_fade rtl
module audio_fifo_underrun_fade_tb;
    import aufifo_pkg::*;

    localparam int RING_DEPTH    = DEF_RING_DEPTH;
    localparam int CHUNK_DEPTH   = DEF_CHUNK_DEPTH;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 400;
    localparam int PHASE_ITEMS   = 60;
    localparam int MAX_PRINTED   = 150;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(2);

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  item_valid;
    logic                  item_stall;
    item_t                 item;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;

    // model of the fifo state
    logic [CHAN_W-1:0]   m_channels;
    logic [FRAMES_W-1:0] m_frames;
    logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    logic [SAMPLE_W-1:0] replay_mem [CHUNK_DEPTH];
    int unsigned         rd_ptr;
    int unsigned         wr_ptr;
    int unsigned         burst_pos;
    int unsigned         burst_len;
    bit                  replay_ok;
    bit                  faded_once;
    bit                  chunk_open;
    bit                  burst_save;
    src_t                burst_src;

    result_t expected_q[$];
    int      errors;
    int      n_items;
    int      n_stored;
    int      n_ring;
    int      n_fade;
    int      n_quiet;
    int      rx_hold;
    bit      steady;

    audio_fifo_underrun_fade u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned chans();
        return (m_channels == '0) ? 1 : m_channels;
    endfunction

    function automatic int unsigned ring_cap();
        int unsigned want;
        int unsigned p;
        want = 2 * m_frames * chans();
        p = 1;
        if (want == 0)
            return 0;
        while (p < want && p < RING_DEPTH)
            p = p << 1;
        return (p < RING_DEPTH) ? p : RING_DEPTH;
    endfunction

    function automatic int unsigned replay_len();
        int unsigned len;
        len = m_frames * chans();
        return (len < CHUNK_DEPTH) ? len : CHUNK_DEPTH;
    endfunction

    // pointers run modulo twice the capacity so full and empty differ
    function automatic int unsigned queued(int unsigned cap);
        return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + 2 * cap - rd_ptr;
    endfunction

    function automatic int unsigned next_ptr(int unsigned p, int unsigned cap);
        return (p + 1 >= 2 * cap) ? 0 : p + 1;
    endfunction

    function automatic int unsigned slot(int unsigned p, int unsigned cap);
        return (p >= cap) ? p - cap : p;
    endfunction

    function automatic void reopen_model();
        rd_ptr = 0;
        wr_ptr = 0;
        foreach (replay_mem[i])
            replay_mem[i] = '0;
        replay_ok  = 1'b0;
        faded_once = 1'b0;
        chunk_open = 1'b0;
        burst_src  = SRC_SILENCE;
        burst_pos  = 0;
        burst_len  = 0;
        burst_save = 1'b0;
    endfunction

    function automatic void apply_config(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_CHANNEL_COUNT)
            m_channels = data[CHAN_W-1:0];
        else if (idx == CFG_CHUNK_FRAMES)
            m_frames = data;
        else
            return;
        reopen_model();
    endfunction

    // advances the model by one word and returns the result it should produce
    function automatic result_t fifo_step(item_t w);
        result_t             r;
        int unsigned         ch;
        int unsigned         cap;
        int unsigned         rlen;
        int unsigned         n;
        logic [SAMPLE_W-1:0] s;
        int                  val;
        int                  sv;
        int                  nf;
        int                  fi;
        ch = chans();
        cap = ring_cap();
        rlen = replay_len();
        val = 0;
        r.accepted = 1'b0;
        if (w.action == ACT_PUSH)
        begin
            r.source = SRC_PUSH;
            if (w.first)
                chunk_open = (cap - queued(cap)) >= w.chunk_samples;
            if (chunk_open && queued(cap) < cap)
            begin
                ring_mem[slot(wr_ptr, cap)] = w.sample;
                wr_ptr = next_ptr(wr_ptr, cap);
                r.accepted = 1'b1;
            end
        end
        else
        begin
            if (w.first)
            begin
                burst_len = w.burst_frames;
                burst_pos = 0;
                burst_save = 1'b0;
                n = w.burst_frames * ch;
                if (w.burst_frames == '0)
                    burst_src = SRC_SILENCE;
                else if (queued(cap) >= n)
                begin
                    burst_src = SRC_RING;
                    faded_once = 1'b0;
                    burst_save = (n <= rlen);
                    if (burst_save)
                        replay_ok = 1'b1;
                end
                else if (replay_ok && !faded_once)
                begin
                    burst_src = SRC_FADE;
                    faded_once = 1'b1;
                end
                else
                    burst_src = SRC_SILENCE;
            end
            n = burst_len * ch;
            r.source = SRC_SILENCE;
            if (burst_pos < n && burst_src != SRC_SILENCE)
            begin
                if (burst_src == SRC_RING)
                begin
                    if (queued(cap) > 0)
                    begin
                        s = ring_mem[slot(rd_ptr, cap)];
                        rd_ptr = next_ptr(rd_ptr, cap);
                        if (burst_save && burst_pos < rlen)
                            replay_mem[burst_pos] = s;
                        val = $signed(s);
                        r.source = SRC_RING;
                    end
                end
                else
                begin
                    // linear fade over the burst, truncated toward zero
                    if (burst_pos < rlen)
                        sv = $signed(replay_mem[burst_pos]);
                    else
                        sv = 0;
                    nf = burst_len;
                    fi = burst_pos / ch;
                    val = (sv * (nf - fi)) / nf;
                    r.source = SRC_FADE;
                end
                burst_pos++;
            end
        end
        r.sample_out = val[SAMPLE_W-1:0];
        r.fill_frames = FILL_W'(queued(cap) / ch);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic take_result(result_t got);
        result_t want;
        if (expected_q.size() == 0)
            report_mismatch($sformatf("result word %h with nothing outstanding", got));
        else
        begin
            want = expected_q.pop_front();
            check_field("sample_out", got.sample_out, want.sample_out);
            check_field("accepted", got.accepted, want.accepted);
            check_field("fill_frames", got.fill_frames, want.fill_frames);
            check_field("source", got.source, want.source);
            case (want.source)
                SRC_RING:    n_ring++;
                SRC_FADE:    n_fade++;
                SRC_SILENCE: n_quiet++;
                default:     n_stored += want.accepted;
            endcase
        end
        rx_hold = steady ? 0 : $urandom_range(0, 9);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid === 1'b1 && !result_stall)
                take_result(result);
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            result_stall = 1'b1;
            rx_hold--;
        end
        else
            result_stall = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d result words outstanding", expected_q.size());
        $display("FAIL audio_fifo_underrun_fade");
        $finish;
    end

    // called and returns at a falling edge; valid stays up for a back-to-back word
    task automatic send_word(item_t w);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item = w;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        expected_q.push_back(fifo_step(w));
        n_items++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        item_valid = 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        apply_config(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic item_t push_word(logic [SAMPLE_W-1:0] s, int unsigned csamp, bit first);
        item_t w;
        w.action = ACT_PUSH;
        w.sample = s;
        w.chunk_samples = first ? CSAMP_W'(csamp) : CSAMP_W'($urandom);
        w.burst_frames = FRAMES_W'($urandom);
        w.first = first;
        return w;
    endfunction

    function automatic item_t pull_word(int unsigned frames, bit first);
        item_t w;
        w.action = ACT_PULL;
        w.sample = SAMPLE_W'($urandom);
        w.chunk_samples = CSAMP_W'($urandom);
        w.burst_frames = first ? FRAMES_W'(frames) : FRAMES_W'($urandom);
        w.first = first;
        return w;
    endfunction

    task automatic push_chunk(int unsigned len, int unsigned count);
        for (int i = 0; i < count; i++)
            send_word(push_word(SAMPLE_W'($urandom), len, i == 0));
    endtask

    task automatic pull_burst(int unsigned frames, int unsigned count);
        for (int i = 0; i < count; i++)
            send_word(pull_word(frames, i == 0));
    endtask

    task automatic test_after_reset();
        send_word(push_word(SAMPLE_W'($urandom), 4, 1'b0));
        send_word(pull_word(5, 1'b0));
        send_word(pull_word(0, 1'b1));
    endtask

    task automatic test_field_extremes();
        send_word(push_word(16'h8000, 4096, 1'b1));
        send_word(push_word(16'h7fff, 0, 1'b1));
        send_word(push_word(16'hffff, 8191, 1'b1));
        send_word(push_word(16'h8000, 1, 1'b1));
        pull_burst(1, 2);
        // ring now empty, so the saved frame comes back faded
        pull_burst(2047, 2);
        pull_burst(1024, 1);
    endtask

    task automatic test_reg_settings();
        write_reg(CFG_CHUNK_FRAMES, CFG_DATA_W'(0));
        send_word(push_word(SAMPLE_W'($urandom), 1, 1'b1));
        send_word(pull_word(1, 1'b1));
        write_reg(CFG_SPARE, CFG_DATA_W'(5));
        send_word(pull_word(1, 1'b1));
        // one channel, two-sample ring, one-sample replay store
        write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(0));
        write_reg(CFG_CHUNK_FRAMES, CFG_DATA_W'(1));
        push_chunk(2, 3);
        pull_burst(1, 1);
        pull_burst(3, 3);
        write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(15));
        write_reg(CFG_CHUNK_FRAMES, CFG_DATA_W'(2047));
        send_word(push_word(SAMPLE_W'($urandom), 4096, 1'b1));
        send_word(pull_word(1, 1'b1));
        write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(8));
        write_reg(CFG_CHUNK_FRAMES, CFG_DATA_W'(1024));
        send_word(push_word(SAMPLE_W'($urandom), 4096, 1'b1));
    endtask

    task automatic random_episode();
        int unsigned ch;
        int unsigned pick;
        int unsigned len;
        int unsigned count;
        item_t       w;
        ch = chans();
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            len = $urandom_range(1, m_frames * ch + 2);
            count = len;
            if ($urandom_range(0, 9) == 0)
                count = $urandom_range(1, len + 2);
            push_chunk(len, count);
        end
        else if (pick < 85)
        begin
            len = $urandom_range(1, m_frames + 2);
            count = len * ch;
            if ($urandom_range(0, 9) == 0)
                count = $urandom_range(1, count + 2);
            pull_burst(len, count);
        end
        else
        begin
            // loose words: stray continuations, odd lengths, full-width fields
            repeat ($urandom_range(1, 4))
            begin
                w.action = ($urandom_range(0, 1) == 0) ? ACT_PUSH : ACT_PULL;
                w.sample = SAMPLE_W'($urandom);
                w.chunk_samples = CSAMP_W'($urandom);
                if ($urandom_range(0, 3) == 0)
                    w.burst_frames = FRAMES_W'($urandom);
                else
                    w.burst_frames = FRAMES_W'($urandom_range(0, m_frames + 2));
                w.first = ($urandom_range(0, 1) == 1);
                send_word(w);
            end
        end
    endtask

    task automatic test_random_traffic();
        int start;
        int phase_end;
        start = n_items;
        while (n_items - start < RANDOM_ITEMS)
        begin
            write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'($urandom_range(0, 3)));
            write_reg(CFG_CHUNK_FRAMES, CFG_DATA_W'($urandom_range(1, 12)));
            steady = ($urandom_range(0, 3) == 0);
            phase_end = n_items + PHASE_ITEMS;
            while (n_items < phase_end)
            begin
                if ($urandom_range(0, 29) == 0)
                    wait_drained();
                random_episode();
            end
            steady = 1'b0;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_valid = 1'b0;
        item = '0;
        steady = 1'b0;
        rx_hold = 0;
        m_channels = RST_CHANNEL_COUNT;
        m_frames = RST_CHUNK_FRAMES;
        reopen_model();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_after_reset();
        test_field_extremes();
        test_reg_settings();
        test_random_traffic();
        wait_drained();

        $display("sent %0d words; %0d pushes stored, %0d ring, %0d faded, %0d silent pulls",
                 n_items, n_stored, n_ring, n_fade, n_quiet);
        $display("register settings swept incl. zero channels, zero and max chunk frames");
        if (errors == 0)
            $display("PASS audio_fifo_underrun_fade");
        else
            $display("FAIL audio_fifo_underrun_fade");
        $finish;
    end

endmodule
